[sv/bpe_pkg.sv]
`timescale 1ns / 1ps
// package: payload types, codes, state encoding and binomial rows of the bezier evaluator
package bpe_pkg;

    localparam int AXES    = 3;
    localparam int Q16_ONE = 65536;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // register index of curve_order on the config port
    localparam int         CFG_CURVE_ORDER = 0;
    localparam logic [3:0] CURVE_ORDER_RST = 4'd7;

    typedef struct packed {
        logic               op;
        logic [3:0]         segment;
        logic [1:0]         axis;
        logic [3:0]         point_index;
        logic signed [31:0] point_value;
        logic [16:0]        time_frac;
    } bpe_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } bpe_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW,
        ST_BASIS,
        ST_WEIGHT,
        ST_ACC,
        ST_DRAIN
    } bpe_state_t;

    typedef enum logic [2:0] {
        MK_TPOW,
        MK_UPOW,
        MK_BASIS,
        MK_WEIGHT,
        MK_ACC
    } bpe_mul_kind_t;

    // pascal rows, entry [r][k] = C(r,k), zero above the diagonal
    localparam logic [9:0] BINOM_ROWS [13][13] = '{
        '{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd3, 10'd3, 10'd1, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd5, 10'd10, 10'd10, 10'd5, 10'd1, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd7, 10'd21, 10'd35, 10'd35, 10'd21, 10'd7,
          10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28,
          10'd8, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd9, 10'd36, 10'd84, 10'd126, 10'd126, 10'd84,
          10'd36, 10'd9, 10'd1, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
          10'd120, 10'd45, 10'd10, 10'd1, 10'd0, 10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462,
          10'd330, 10'd165, 10'd55, 10'd11, 10'd1, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
          10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
    };

endpackage

[sv/bpe_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/bezier_point_evaluator.sv]
`timescale 1ns / 1ps
// top level: bezier point evaluator, bernstein form over three axes
//
//  channel   ports                          direction  beat
//  config    psel penable pwrite paddr ...  in/out     one curve_order write or read
//  input     s_valid s_ready s_item         in         load one control point, or evaluate
//  result    m_valid m_ready m_item         out        pos_x, pos_y, pos_z of one evaluate
//
//  a load beat goes straight into the control point ram when it is taken
//  an evaluate beat is worked through by the one shared multiplier: the accept,
//  2n power steps for curve order n, n+1 basis, n+1 weight and 3(n+1)
//  multiply-accumulate steps, then a drain of the pipe
//  s_ready is high only while the sequencer is idle; a finished result waits in the
//  output register, so new beats are still taken while m_valid is stalled, and the next
//  evaluate holds in drain until that register frees
//  synchronous active-low reset; the control point ram has no reset and no clear pass
module bezier_point_evaluator
    import bpe_pkg::*;
#(
    parameter int SEGMENTS  = 16,
    parameter int MAX_ORDER = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  bpe_in_t     s_item,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output bpe_out_t    m_item
);

    localparam int PTS    = MAX_ORDER + 1;
    localparam int IDX_W  = $clog2(PTS);
    localparam int ROWS   = SEGMENTS * AXES;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int DEPTH  = ROWS * PTS;
    localparam int ADDR_W = $clog2(DEPTH);

    // tag that rides along with each product through the shared multiplier
    typedef struct packed {
        logic             valid;
        bpe_mul_kind_t    kind;
        logic             first;
        logic             last;
        logic [1:0]       axis;
        logic [IDX_W-1:0] idx;
    } mul_tag_t;

    // ---------------------------------------------------------------------------------------
    // config register
    // ---------------------------------------------------------------------------------------
    logic [3:0] curve_order_reg;
    logic       cfg_sel;
    logic       cfg_we;

    assign cfg_sel = (paddr[2] == 1'(CFG_CURVE_ORDER));
    assign cfg_we  = psel & penable & pwrite & cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? {28'd0, curve_order_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_order_reg <= CURVE_ORDER_RST;
        end else if (cfg_we) begin
            curve_order_reg <= pwdata[3:0];
        end
    end

    // order clamped into 1..MAX_ORDER
    logic [IDX_W-1:0] n_eff;

    always_comb begin
        if (curve_order_reg == 4'd0) begin
            n_eff = IDX_W'(1);
        end else if ({28'd0, curve_order_reg} > 32'(MAX_ORDER)) begin
            n_eff = IDX_W'(MAX_ORDER);
        end else begin
            n_eff = IDX_W'(curve_order_reg);
        end
    end

    // ---------------------------------------------------------------------------------------
    // state and sequencer registers
    // ---------------------------------------------------------------------------------------
    bpe_state_t state_reg, state_next;

    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] j_reg;
    logic [1:0]       axis_reg;
    logic             ph_reg;        // power phase: low t step, high u step
    logic [ROW_W-1:0] row_base_reg;  // segment * AXES
    logic [16:0]      t_reg;
    logic [16:0]      u_reg;

    // work registers of the shared unit
    logic [16:0] tp_reg [PTS];       // t^j, Q1.16
    logic [16:0] up_reg [PTS];       // (1-t)^j, Q1.16
    logic [25:0] w_reg  [PTS];       // basis, then binomial weight

    mul_tag_t                  pend_reg, pend_next;
    mul_tag_t                  tag_reg;
    logic signed [59:0]        prod_reg;
    logic signed [61:0]        acc_reg;
    logic                      fin_valid_reg;
    logic [1:0]                fin_axis_reg;
    logic signed [31:0]        res_reg [AXES];

    logic                      m_valid_reg;
    bpe_out_t                  m_item_reg;

    // ---------------------------------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------------------------------
    logic        accept;
    logic        seg_ok;
    logic        load_ok;
    logic        eval_start;
    logic [16:0] t_in;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid & s_ready;
    assign seg_ok     = (32'(s_item.segment) < SEGMENTS);
    assign load_ok    = seg_ok && (32'(s_item.axis) < AXES)
                        && (32'(s_item.point_index) <= MAX_ORDER);
    assign eval_start = accept && (s_item.op == OP_EVAL) && seg_ok;
    // time above one saturates to one
    assign t_in       = (s_item.time_frac > 17'(Q16_ONE)) ? 17'(Q16_ONE) : s_item.time_frac;

    // ---------------------------------------------------------------------------------------
    // control point ram: loads write, the accumulate phase reads
    // ---------------------------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    assign ram_we    = accept && (s_item.op == OP_LOAD) && load_ok;
    assign ram_waddr = ADDR_W'((32'(s_item.segment) * AXES + 32'(s_item.axis)) * PTS
                               + 32'(s_item.point_index));
    assign ram_raddr = ADDR_W'((32'(row_base_reg) + 32'(axis_reg)) * PTS + 32'(j_reg));

    bpe_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_cp_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_item.point_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------------------------
    // read ports of the work registers, one address each
    // ---------------------------------------------------------------------------------------
    logic [IDX_W-1:0] tp_ridx, up_ridx, w_ridx;
    logic [16:0]      tp_rd, up_rd;
    logic [25:0]      w_rd;
    logic [9:0]       binom_rd;

    always_comb begin
        if (state_reg == ST_POW) begin
            tp_ridx = j_reg - 1'b1;
            up_ridx = j_reg - 1'b1;
        end else begin
            tp_ridx = j_reg;
            up_ridx = n_reg - j_reg;
        end
        w_ridx = (state_reg == ST_WEIGHT) ? j_reg : pend_reg.idx;
    end

    assign tp_rd    = tp_reg[tp_ridx];
    assign up_rd    = up_reg[up_ridx];
    assign w_rd     = w_reg[w_ridx];
    assign binom_rd = BINOM_ROWS[4'(n_reg)][4'(j_reg)];

    // ---------------------------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------------------------
    logic pipe_empty;
    logic out_free;
    logic out_load;

    assign pipe_empty = !pend_reg.valid && !tag_reg.valid && !fin_valid_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (eval_start) state_next = ST_POW;
            end
            ST_POW: begin
                if (ph_reg && (j_reg == n_reg)) state_next = ST_BASIS;
            end
            ST_BASIS: begin
                if (j_reg == '0) state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                if (j_reg == '0) state_next = ST_ACC;
            end
            ST_ACC: begin
                if ((j_reg == n_reg) && (axis_reg == 2'(AXES - 1))) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (pipe_empty && out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // sequencer outputs: what the shared multiplier does this cycle
    // ---------------------------------------------------------------------------------------
    mul_tag_t           iss_tag;
    logic signed [32:0] iss_a;
    logic signed [26:0] iss_b;

    always_comb begin
        iss_tag   = '0;
        iss_a     = '0;
        iss_b     = '0;
        pend_next = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_POW: begin
                // chained powers, t and u interleaved so each result is back in time
                iss_tag.valid = 1'b1;
                iss_tag.idx   = j_reg;
                if (ph_reg) begin
                    iss_tag.kind = MK_UPOW;
                    iss_a        = {16'd0, up_rd};
                    iss_b        = {10'd0, u_reg};
                end else begin
                    iss_tag.kind = MK_TPOW;
                    iss_a        = {16'd0, tp_rd};
                    iss_b        = {10'd0, t_reg};
                end
            end
            ST_BASIS: begin
                // descending j, so up[n] is never read right as it lands
                iss_tag.valid = 1'b1;
                iss_tag.kind  = MK_BASIS;
                iss_tag.idx   = j_reg;
                iss_a         = {16'd0, tp_rd};
                iss_b         = {10'd0, up_rd};
            end
            ST_WEIGHT: begin
                iss_tag.valid = 1'b1;
                iss_tag.kind  = MK_WEIGHT;
                iss_tag.idx   = j_reg;
                iss_a         = {23'd0, binom_rd};
                iss_b         = {1'b0, w_rd};
            end
            ST_ACC: begin
                // ram address goes out now, the multiply follows with the read data
                pend_next.valid = 1'b1;
                pend_next.kind  = MK_ACC;
                pend_next.idx   = j_reg;
                pend_next.axis  = axis_reg;
                pend_next.first = (j_reg == '0);
                pend_next.last  = (j_reg == n_reg);
            end
            ST_DRAIN: begin
                out_load = pipe_empty && out_free;
            end
            default: ;
        endcase
    end

    // operand select of the shared multiplier, accumulate beats take priority
    mul_tag_t           mul_tag;
    logic signed [32:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [59:0] prod_next;

    always_comb begin
        if (pend_reg.valid) begin
            mul_tag = pend_reg;
            mul_a   = {ram_rdata[31], ram_rdata};
            mul_b   = {1'b0, w_rd};
        end else begin
            mul_tag = iss_tag;
            mul_a   = iss_a;
            mul_b   = iss_b;
        end
        prod_next = mul_a * mul_b;
    end

    // ---------------------------------------------------------------------------------------
    // writeback: Q1.16 rounding half up, and round plus saturate of the accumulator
    // ---------------------------------------------------------------------------------------
    logic [33:0]        prod_rnd;
    logic [16:0]        q16_rnd;
    logic signed [61:0] acc_rnd;
    logic signed [45:0] acc_q;
    logic signed [31:0] acc_sat;

    assign prod_rnd = prod_reg[33:0] + 34'd32768;
    assign q16_rnd  = prod_rnd[32:16];
    assign acc_rnd  = acc_reg + 62'sd32768;
    assign acc_q    = acc_rnd[61:16];

    always_comb begin
        if ((&acc_q[45:31]) || !(|acc_q[45:31])) begin
            acc_sat = acc_q[31:0];
        end else if (acc_q[45]) begin
            acc_sat = 32'sh8000_0000;
        end else begin
            acc_sat = 32'sh7fff_ffff;
        end
    end

    // ---------------------------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_reg.valid <= 1'b0;
            tag_reg.valid  <= 1'b0;
            fin_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            tag_reg       <= mul_tag;
            fin_valid_reg <= tag_reg.valid && (tag_reg.kind == MK_ACC) && tag_reg.last;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // counters and datapath registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (eval_start) begin
                    n_reg        <= n_eff;
                    t_reg        <= t_in;
                    u_reg        <= 17'(Q16_ONE) - t_in;
                    row_base_reg <= ROW_W'(32'(s_item.segment) * AXES);
                    j_reg        <= IDX_W'(1);
                    ph_reg       <= 1'b0;
                    axis_reg     <= 2'(AXIS_X);
                    tp_reg[0]    <= 17'(Q16_ONE);
                    up_reg[0]    <= 17'(Q16_ONE);
                end
            end
            ST_POW: begin
                ph_reg <= ~ph_reg;
                if (ph_reg && (j_reg != n_reg)) j_reg <= j_reg + 1'b1;
            end
            ST_BASIS: begin
                j_reg <= (j_reg == '0) ? n_reg : j_reg - 1'b1;
            end
            ST_WEIGHT: begin
                if (j_reg != '0) j_reg <= j_reg - 1'b1;
            end
            ST_ACC: begin
                if (j_reg == n_reg) begin
                    j_reg    <= '0;
                    axis_reg <= axis_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_DRAIN: ;
            default: ;
        endcase

        prod_reg <= prod_next;

        if (tag_reg.valid) begin
            unique case (tag_reg.kind)
                MK_TPOW:   tp_reg[tag_reg.idx] <= q16_rnd;
                MK_UPOW:   up_reg[tag_reg.idx] <= q16_rnd;
                MK_BASIS:  w_reg[tag_reg.idx]  <= {9'd0, q16_rnd};
                MK_WEIGHT: w_reg[tag_reg.idx]  <= prod_reg[25:0];
                MK_ACC: begin
                    if (tag_reg.first) begin
                        acc_reg <= {{2{prod_reg[59]}}, prod_reg};
                    end else begin
                        acc_reg <= acc_reg + {{2{prod_reg[59]}}, prod_reg};
                    end
                    fin_axis_reg <= tag_reg.axis;
                end
                default: ;
            endcase
        end

        if (fin_valid_reg) begin
            res_reg[fin_axis_reg] <= acc_sat;
        end

        if (out_load) begin
            m_item_reg.pos_x <= res_reg[AXIS_X];
            m_item_reg.pos_y <= res_reg[AXIS_Y];
            m_item_reg.pos_z <= res_reg[AXIS_Z];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
